@@ sv/rdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

   localparam int FRAC_BITS = 14;
   localparam int FIELD_W   = 16;

   // square root datapath (shared by both root chains)
   localparam int ROOT_X_W  = 62;
   // normalized direction length: 31 steps, first trial bit 2^60
   localparam int SQ1_STEPS = 31;
   localparam int SQ1_TOP   = 60;
   localparam int LEN_W     = 31;
   // discriminant root: 20 steps, first trial bit 2^38
   localparam int SQ2_STEPS = 20;
   localparam int SQ2_TOP   = 38;
   localparam int D2_W      = 40;
   localparam int ROOT_W    = 20;

   // restoring division of the scaled direction by its length
   localparam int NUM_W     = 46;
   localparam int QUO_W     = 15;
   localparam int DIV_STEPS = QUO_W;
   localparam int SH_W      = 4;

   localparam int PART_W    = 26;

   typedef struct packed {
      logic [2:0][FIELD_W-1:0] dir;
      logic [2:0][FIELD_W-1:0] norm;
      logic [FIELD_W-1:0]      eta;
      logic [4:0]              shift;
      logic                    zero;
   } ray_type;

   typedef struct packed {
      logic [2:0][PART_W-1:0]  part;
      logic [2:0][FIELD_W-1:0] norm;
      logic                    ok;
   } fin_type;

   localparam int SIDE_W = ($bits(ray_type) > $bits(fin_type)) ?
                           $bits(ray_type) : $bits(fin_type);

   typedef struct packed {
      logic [ROOT_X_W-1:0] x;
      logic [ROOT_X_W-1:0] res;
      logic [SIDE_W-1:0]   side;
   } cell_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0] rem;
      logic [2:0][QUO_W-1:0] quo;
      logic [LEN_W-1:0]      len;
      logic [SIDE_W-1:0]     side;
   } div_type;

endpackage

`default_nettype wire

@@ sv/rdc_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [15:0]        eta_ratio;

   modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
                   input ready);
   modport sink (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio,
                 output ready);
endinterface

`default_nettype wire

@@ sv/rdc_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic               refracted_ok;

   modport source (output valid, out_x, out_y, out_z, refracted_ok, input ready);
   modport sink (input valid, out_x, out_y, out_z, refracted_ok, output ready);
endinterface

`default_nettype wire

@@ sv/rdc_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One digit of a bit-by-bit square root; trial bit is fixed per position.
module rdc_sqrt_cell (
   input  wire logic                           clock,
   input  wire logic                           step_en,
   input  wire logic [rdc_pkg::ROOT_X_W-1:0]   step_bit,
   input  wire rdc_pkg::cell_type              cell_i,
   output rdc_pkg::cell_type                   cell_o
);

   logic [rdc_pkg::ROOT_X_W-1:0] trial;
   rdc_pkg::cell_type            cell_in;
   rdc_pkg::cell_type            cell_ff;

   always_comb begin
      trial   = cell_i.res + step_bit;
      cell_in = cell_i;
      if (cell_i.x >= trial) begin
         cell_in.x   = cell_i.x - trial;
         cell_in.res = (cell_i.res >> 1) + step_bit;
      end else begin
         cell_in.res = cell_i.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

`default_nettype wire

@@ sv/rdc_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One quotient bit for each of three lanes sharing a divisor.
module rdc_div_cell (
   input  wire logic                        clock,
   input  wire logic                        step_en,
   input  wire logic [rdc_pkg::SH_W-1:0]    step_sh,
   input  wire rdc_pkg::div_type            div_i,
   output rdc_pkg::div_type                 div_o
);

   logic [rdc_pkg::NUM_W-1:0] divisor;
   rdc_pkg::div_type          div_in;
   rdc_pkg::div_type          div_ff;

   always_comb begin
      divisor = rdc_pkg::NUM_W'(div_i.len) << step_sh;
      div_in  = div_i;
      for (int i = 0; i < 3; i++) begin
         if (div_i.rem[i] >= divisor) begin
            div_in.rem[i] = div_i.rem[i] - divisor;
            div_in.quo[i] = {div_i.quo[i][rdc_pkg::QUO_W-2:0], 1'b1};
         end else begin
            div_in.quo[i] = {div_i.quo[i][rdc_pkg::QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         div_ff <= div_in;
      end
   end

   assign div_o = div_ff;

endmodule

`default_nettype wire

@@ sv/refraction_direction_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle, unless the pipeline is full while the output beat
//   is held; the length root (31 cells), the 15-bit divider (15 cells) and the
//   discriminant root (20 cells) are chains of one-step cells.
// Each stage advances independently, so bubbles fill while a result waits.
// Reset (synchronous, active high) empties every stage; data registers are not reset.

module refraction_direction_core (
   input wire logic  clock,
   input wire logic  reset,
   rdc_req_if.sink   req_bus,
   rdc_rsp_if.source rsp_bus
);

   // stage map
   localparam int ST_IN   = 0;
   localparam int ST_NRM  = 1;
   localparam int ST_SQ1  = 2;
   localparam int ST_PREP = ST_SQ1 + rdc_pkg::SQ1_STEPS;
   localparam int ST_DIV  = ST_PREP + 1;
   localparam int ST_A    = ST_DIV + rdc_pkg::DIV_STEPS;
   localparam int ST_C    = ST_A + 1;
   localparam int ST_D    = ST_C + 1;
   localparam int ST_E    = ST_D + 1;
   localparam int ST_SQ2  = ST_E + 1;
   localparam int ST_OUT  = ST_SQ2 + rdc_pkg::SQ2_STEPS;
   localparam int NS      = ST_OUT + 1;

   localparam int RAY_W = $bits(rdc_pkg::ray_type);
   localparam int FIN_W = $bits(rdc_pkg::fin_type);

   localparam logic signed [47:0] RndHalf = 48'sd1 <<< (rdc_pkg::FRAC_BITS - 1);
   localparam logic signed [47:0] OneQ    = 48'sd1 <<< rdc_pkg::FRAC_BITS;

   // round half toward plus infinity, then drop the fraction
   function automatic logic signed [47:0] rnd_q(input logic signed [47:0] v);
      rnd_q = (v + RndHalf) >>> rdc_pkg::FRAC_BITS;
   endfunction

   // ---------------------------------------------------------------
   // Flow control: a stage advances unless it and every stage after it
   // are full while the output beat is held.
   // ---------------------------------------------------------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] v_in;
   logic [NS-1:0] adv;

   always_comb begin
      for (int k = 0; k < NS; k++) begin
         adv[k] = rsp_bus.ready || ((v_ff | NS'((NS'(1) << k) - NS'(1))) != {NS{1'b1}});
      end
      v_in[0] = adv[0] ? req_bus.valid : v_ff[0];
      for (int k = 1; k < NS; k++) begin
         v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_bus.ready = adv[ST_IN];

   // ---------------------------------------------------------------
   // Input stage: capture the beat and the squared length.
   // ---------------------------------------------------------------
   rdc_pkg::ray_type  s0_ray_ff;
   rdc_pkg::ray_type  s0_ray_in;
   logic [31:0]       s0_sq_ff;
   logic [31:0]       s0_sq_in;
   logic signed [31:0] px, py, pz;

   always_comb begin
      px = req_bus.dir_x * req_bus.dir_x;
      py = req_bus.dir_y * req_bus.dir_y;
      pz = req_bus.dir_z * req_bus.dir_z;
      s0_sq_in = 32'(px) + 32'(py) + 32'(pz);
      s0_ray_in.dir[0]  = req_bus.dir_x;
      s0_ray_in.dir[1]  = req_bus.dir_y;
      s0_ray_in.dir[2]  = req_bus.dir_z;
      s0_ray_in.norm[0] = req_bus.norm_x;
      s0_ray_in.norm[1] = req_bus.norm_y;
      s0_ray_in.norm[2] = req_bus.norm_z;
      s0_ray_in.eta     = req_bus.eta_ratio;
      s0_ray_in.shift   = '0;
      s0_ray_in.zero    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         s0_ray_ff <= s0_ray_in;
         s0_sq_ff  <= s0_sq_in;
      end
   end

   // ---------------------------------------------------------------
   // Normalize: shift the squared length left by an even amount until it
   // reaches [2^60, 2^62); half that amount scales the components later.
   // ---------------------------------------------------------------
   rdc_pkg::cell_type nrm_ff;
   rdc_pkg::cell_type nrm_in;
   rdc_pkg::ray_type  nrm_ray;
   logic [rdc_pkg::ROOT_X_W-1:0] nrm_x;
   logic [4:0]        nrm_sh;

   always_comb begin
      nrm_x  = rdc_pkg::ROOT_X_W'(s0_sq_ff);
      nrm_sh = '0;
      for (int j = 4; j >= 0; j--) begin
         if (nrm_x < (rdc_pkg::ROOT_X_W'(1) << (rdc_pkg::ROOT_X_W - (2 << j)))) begin
            nrm_x  = nrm_x << (2 << j);
            nrm_sh = nrm_sh + 5'(1 << j);
         end
      end
      nrm_ray       = s0_ray_ff;
      nrm_ray.shift = nrm_sh;
      nrm_ray.zero  = (s0_sq_ff == '0);
      nrm_in.x      = nrm_x;
      nrm_in.res    = '0;
      nrm_in.side   = rdc_pkg::SIDE_W'(nrm_ray);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_NRM]) begin
         nrm_ff <= nrm_in;
      end
   end

   // ---------------------------------------------------------------
   // Length root: one cell per result bit.
   // ---------------------------------------------------------------
   rdc_pkg::cell_type sq1_link [rdc_pkg::SQ1_STEPS+1];
   assign sq1_link[0] = nrm_ff;

   for (genvar g = 0; g < rdc_pkg::SQ1_STEPS; g++) begin : g_sq1
      rdc_sqrt_cell u_cell (
         .clock    (clock),
         .step_en  (adv[ST_SQ1+g]),
         .step_bit (rdc_pkg::ROOT_X_W'(1) << (rdc_pkg::SQ1_TOP - 2*g)),
         .cell_i   (sq1_link[g]),
         .cell_o   (sq1_link[g+1])
      );
   end

   // ---------------------------------------------------------------
   // Divider setup: numerator |d| << s << F plus half the length.
   // ---------------------------------------------------------------
   rdc_pkg::div_type prep_ff;
   rdc_pkg::div_type prep_in;
   rdc_pkg::ray_type prep_ray;
   logic [rdc_pkg::LEN_W-1:0]   prep_len;
   logic signed [15:0]          prep_d;
   logic [15:0]                 prep_mag;

   always_comb begin
      prep_ray = rdc_pkg::ray_type'(sq1_link[rdc_pkg::SQ1_STEPS].side[RAY_W-1:0]);
      prep_len = sq1_link[rdc_pkg::SQ1_STEPS].res[rdc_pkg::LEN_W-1:0];
      prep_in.len  = prep_len;
      prep_in.side = sq1_link[rdc_pkg::SQ1_STEPS].side;
      prep_d   = '0;
      prep_mag = '0;
      for (int i = 0; i < 3; i++) begin
         prep_d   = prep_ray.dir[i];
         prep_mag = prep_d[15] ? 16'(-prep_d) : 16'(prep_d);
         prep_in.rem[i] = ((rdc_pkg::NUM_W'(prep_mag) << prep_ray.shift)
                           << rdc_pkg::FRAC_BITS) + rdc_pkg::NUM_W'(prep_len >> 1);
         prep_in.quo[i] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_PREP]) begin
         prep_ff <= prep_in;
      end
   end

   // ---------------------------------------------------------------
   // Divider: one quotient bit per cell, most significant first.
   // ---------------------------------------------------------------
   rdc_pkg::div_type div_link [rdc_pkg::DIV_STEPS+1];
   assign div_link[0] = prep_ff;

   for (genvar g = 0; g < rdc_pkg::DIV_STEPS; g++) begin : g_div
      rdc_div_cell u_cell (
         .clock   (clock),
         .step_en (adv[ST_DIV+g]),
         .step_sh (rdc_pkg::SH_W'(rdc_pkg::DIV_STEPS - 1 - g)),
         .div_i   (div_link[g]),
         .div_o   (div_link[g+1])
      );
   end

   // ---------------------------------------------------------------
   // Stage A: signed unit direction, dt and eta squared.
   // ---------------------------------------------------------------
   rdc_pkg::ray_type   a_ray;
   logic signed [15:0] a_uv_w [3];
   logic signed [15:0] a_n_w;
   logic signed [47:0] a_acc, a_u48, a_n48, a_e48;
   logic signed [15:0] a_uv_ff [3];
   logic signed [15:0] a_norm_ff [3];
   logic [15:0]        a_eta_ff;
   logic signed [19:0] a_dt_ff;
   logic [18:0]        a_e2_ff;
   logic               a_zero_ff;

   always_comb begin
      a_ray = rdc_pkg::ray_type'(div_link[rdc_pkg::DIV_STEPS].side[RAY_W-1:0]);
      a_acc = '0;
      a_n_w = '0;
      a_u48 = '0;
      a_n48 = '0;
      for (int i = 0; i < 3; i++) begin
         a_uv_w[i] = $signed({1'b0, div_link[rdc_pkg::DIV_STEPS].quo[i]});
         if (a_ray.dir[i][15]) begin
            a_uv_w[i] = -a_uv_w[i];
         end
         a_n_w = a_ray.norm[i];
         a_u48 = 48'(a_uv_w[i]);
         a_n48 = 48'(a_n_w);
         a_acc = a_acc + a_u48 * a_n48;
      end
      a_e48 = $signed({32'b0, a_ray.eta});
   end

   always_ff @(posedge clock) begin
      if (adv[ST_A]) begin
         for (int i = 0; i < 3; i++) begin
            a_uv_ff[i]   <= a_uv_w[i];
            a_norm_ff[i] <= a_ray.norm[i];
         end
         a_eta_ff  <= a_ray.eta;
         a_dt_ff   <= 20'(rnd_q(a_acc));
         a_e2_ff   <= 19'(rnd_q(a_e48 * a_e48));
         a_zero_ff <= a_ray.zero;
      end
   end

   // ---------------------------------------------------------------
   // Stage C: dt squared and the tangential part uv - n*dt.
   // ---------------------------------------------------------------
   logic signed [47:0] c_dt48, c_n48, c_u48, c_t48 [3];
   logic signed [21:0] c_dd_ff;
   logic signed [22:0] c_t_ff [3];
   logic signed [15:0] c_norm_ff [3];
   logic [15:0]        c_eta_ff;
   logic [18:0]        c_e2_ff;
   logic               c_zero_ff;

   always_comb begin
      c_dt48 = 48'(a_dt_ff);
      c_n48  = '0;
      c_u48  = '0;
      for (int i = 0; i < 3; i++) begin
         c_n48    = 48'(a_norm_ff[i]);
         c_u48    = 48'(a_uv_ff[i]);
         c_t48[i] = c_u48 - rnd_q(c_n48 * c_dt48);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_C]) begin
         c_dd_ff <= 22'(rnd_q(c_dt48 * c_dt48));
         for (int i = 0; i < 3; i++) begin
            c_t_ff[i]    <= c_t48[i][22:0];
            c_norm_ff[i] <= a_norm_ff[i];
         end
         c_eta_ff  <= a_eta_ff;
         c_e2_ff   <= a_e2_ff;
         c_zero_ff <= a_zero_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage D: eta^2 * (1 - dd) and the scaled tangential part.
   // ---------------------------------------------------------------
   logic signed [47:0] d_e2_48, d_dd48, d_eta48, d_t48;
   logic signed [47:0] d_part48 [3];
   logic signed [43:0] d_pr_ff;
   logic signed [rdc_pkg::PART_W-1:0] d_part_ff [3];
   logic signed [15:0] d_norm_ff [3];
   logic               d_zero_ff;

   always_comb begin
      d_e2_48 = $signed({29'b0, c_e2_ff});
      d_dd48  = 48'(c_dd_ff);
      d_eta48 = $signed({32'b0, c_eta_ff});
      d_t48   = '0;
      for (int i = 0; i < 3; i++) begin
         d_t48       = 48'(c_t_ff[i]);
         d_part48[i] = rnd_q(d_eta48 * d_t48);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_D]) begin
         d_pr_ff <= 44'(d_e2_48 * (OneQ - d_dd48));
         for (int i = 0; i < 3; i++) begin
            d_part_ff[i] <= d_part48[i][rdc_pkg::PART_W-1:0];
            d_norm_ff[i] <= c_norm_ff[i];
         end
         d_zero_ff <= c_zero_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage E: discriminant and refraction decision; feed the root chain.
   // ---------------------------------------------------------------
   logic signed [47:0] e_pr48, e_d2;
   rdc_pkg::fin_type   e_fin;
   rdc_pkg::cell_type  e_ff;
   rdc_pkg::cell_type  e_in;

   always_comb begin
      e_pr48 = 48'(d_pr_ff);
      e_d2   = OneQ * OneQ - e_pr48;
      for (int i = 0; i < 3; i++) begin
         e_fin.part[i] = d_part_ff[i];
         e_fin.norm[i] = d_norm_ff[i];
      end
      e_fin.ok  = !d_zero_ff && (e_d2 > 48'sd0);
      e_in.x    = e_fin.ok ? rdc_pkg::ROOT_X_W'(e_d2[rdc_pkg::D2_W-1:0]) : '0;
      e_in.res  = '0;
      e_in.side = rdc_pkg::SIDE_W'(e_fin);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_E]) begin
         e_ff <= e_in;
      end
   end

   // ---------------------------------------------------------------
   // Discriminant root chain.
   // ---------------------------------------------------------------
   rdc_pkg::cell_type sq2_link [rdc_pkg::SQ2_STEPS+1];
   assign sq2_link[0] = e_ff;

   for (genvar g = 0; g < rdc_pkg::SQ2_STEPS; g++) begin : g_sq2
      rdc_sqrt_cell u_cell (
         .clock    (clock),
         .step_en  (adv[ST_SQ2+g]),
         .step_bit (rdc_pkg::ROOT_X_W'(1) << (rdc_pkg::SQ2_TOP - 2*g)),
         .cell_i   (sq2_link[g]),
         .cell_o   (sq2_link[g+1])
      );
   end

   // ---------------------------------------------------------------
   // Output stage: subtract n*root, saturate, zero when not refracted.
   // ---------------------------------------------------------------
   rdc_pkg::fin_type   o_fin;
   logic signed [47:0] o_root48, o_n48, o_p48, o_r48;
   logic signed [15:0] o_n_w;
   logic signed [15:0] o_res_w [3];
   logic signed [15:0] o_out_ff [3];
   logic               o_ok_ff;

   always_comb begin
      o_fin    = rdc_pkg::fin_type'(sq2_link[rdc_pkg::SQ2_STEPS].side[FIN_W-1:0]);
      o_root48 = $signed({28'b0, sq2_link[rdc_pkg::SQ2_STEPS].res[rdc_pkg::ROOT_W-1:0]});
      o_n_w    = '0;
      o_n48    = '0;
      o_p48    = '0;
      o_r48    = '0;
      for (int i = 0; i < 3; i++) begin
         o_n_w = o_fin.norm[i];
         o_n48 = 48'(o_n_w);
         o_p48 = 48'($signed(o_fin.part[i]));
         o_r48 = o_p48 - rnd_q(o_n48 * o_root48);
         if (!o_fin.ok) begin
            o_res_w[i] = '0;
         end else if (o_r48 > 48'sd32767) begin
            o_res_w[i] = 16'sh7fff;
         end else if (o_r48 < -48'sd32768) begin
            o_res_w[i] = 16'sh8000;
         end else begin
            o_res_w[i] = o_r48[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         for (int i = 0; i < 3; i++) begin
            o_out_ff[i] <= o_res_w[i];
         end
         o_ok_ff <= o_fin.ok;
      end
   end

   assign rsp_bus.valid        = v_ff[ST_OUT];
   assign rsp_bus.out_x        = o_out_ff[0];
   assign rsp_bus.out_y        = o_out_ff[1];
   assign rsp_bus.out_z        = o_out_ff[2];
   assign rsp_bus.refracted_ok = o_ok_ff;

`ifndef SYNTHESIS
   a_no_refract_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.refracted_ok |->
         rsp_bus.out_x == 16'sd0 && rsp_bus.out_y == 16'sd0 && rsp_bus.out_z == 16'sd0)
      else $error("non-refracted beat carries a nonzero vector");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (&v_ff) && !rsp_bus.ready)
      else $error("input stalled while the pipeline has a free stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> v_ff[ST_IN])
      else $error("accepted beat did not enter the first stage");

   a_held_output: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> v_ff[ST_OUT] && $stable(o_ok_ff))
      else $error("stalled output stage lost its beat");
`endif

endmodule

`default_nettype wire

@@ tb/tb_refraction_direction_core.sv @@
`timescale 1ns / 1ps

module tb_refraction_direction_core;

   localparam int LATENCY   = 74;
   localparam int MAX_GAP   = 13;
   localparam int N_RANDOM  = 850;
   localparam int IDLE_LIMIT = 4 * (LATENCY + 2 * MAX_GAP + 20);

   // one stimulus beat of the request channel
   typedef struct {
      logic signed [15:0] dx, dy, dz;
      logic signed [15:0] nx, ny, nz;
      logic [15:0]        eta;
   } ray_beat_type;

   // one result beat of the response channel
   typedef struct {
      logic signed [15:0] ox, oy, oz;
      logic               ok;
   } refr_beat_type;

   // directed row: expected result typed in only when has_exp is set
   typedef struct {
      ray_beat_type  ray;
      bit            has_exp;
      refr_beat_type exp_val;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rdc_req_if req_bus ();
   rdc_rsp_if rsp_bus ();

   refraction_direction_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   refr_beat_type refr_queue[$];
   int            mismatch_cnt = 0;
   int            idle_cycles  = 0;
   bit            stim_done    = 1'b0;
   bit            rsp_stall_on = 1'b1;

   // ------------------------------------------------------------------
   // Fixed-point helpers mirroring the block's arithmetic
   // ------------------------------------------------------------------

   // round half toward plus infinity, drop FRAC_BITS fraction bits
   function automatic longint fx_round(longint x);
      return (x + (longint'(1) <<< (rdc_pkg::FRAC_BITS - 1))) >>> rdc_pkg::FRAC_BITS;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x   = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[15:0];
   endfunction

   // compute refracted direction for one ray
   function automatic refr_beat_type refract(ray_beat_type r);
      refr_beat_type   res;
      longint          d[3], n[3], uv[3];
      longint          eta, one, dot, dt, dd, e2, d2, root, t, q;
      longint unsigned sq, len, mag, num;
      int              s;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      n[0] = r.nx; n[1] = r.ny; n[2] = r.nz;
      eta  = longint'({1'b0, r.eta});
      one  = longint'(1) <<< rdc_pkg::FRAC_BITS;
      res  = '{ox: '0, oy: '0, oz: '0, ok: 1'b0};
      sq   = 0;
      for (int i = 0; i < 3; i++) sq += longint'(d[i] * d[i]);
      // zero direction: rejected like total internal reflection
      if (sq == 0) return res;
      s = 0;
      while (sq < (64'd1 << 60)) begin
         sq <<= 2;
         s++;
      end
      len = floor_sqrt(sq);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         mag   = (d[i] < 0) ? -d[i] : d[i];
         num   = (mag << s) << rdc_pkg::FRAC_BITS;
         q     = (num + (len >> 1)) / len;
         uv[i] = (d[i] < 0) ? -q : q;
         dot  += uv[i] * n[i];
      end
      dt = fx_round(dot);
      dd = fx_round(dt * dt);
      e2 = fx_round(eta * eta);
      d2 = one * one - e2 * (one - dd);
      // non-positive discriminant: total internal reflection
      if (d2 <= 0) return res;
      root = floor_sqrt(d2);
      t = uv[0] - fx_round(n[0] * dt);
      res.ox = clamp16(fx_round(eta * t) - fx_round(n[0] * root));
      t = uv[1] - fx_round(n[1] * dt);
      res.oy = clamp16(fx_round(eta * t) - fx_round(n[1] * root));
      t = uv[2] - fx_round(n[2] * dt);
      res.oz = clamp16(fx_round(eta * t) - fx_round(n[2] * root));
      res.ok = 1'b1;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid     = 1'b0;
      req_bus.dir_x     = '0;
      req_bus.dir_y     = '0;
      req_bus.dir_z     = '0;
      req_bus.norm_x    = '0;
      req_bus.norm_y    = '0;
      req_bus.norm_z    = '0;
      req_bus.eta_ratio = '0;
   end

   // drive one beat, hold it until accepted, expectation pushed on acceptance;
   // valid stays high afterwards so a beat with no gap follows right away
   task automatic send_ray(ray_beat_type r, bit has_exp, refr_beat_type exp_val);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.dir_x     <= r.dx;
      req_bus.dir_y     <= r.dy;
      req_bus.dir_z     <= r.dz;
      req_bus.norm_x    <= r.nx;
      req_bus.norm_y    <= r.ny;
      req_bus.norm_z    <= r.nz;
      req_bus.eta_ratio <= r.eta;
      do @(posedge clock); while (!req_bus.ready);
      refr_queue.push_back(has_exp ? exp_val : refract(r));
   endtask

   function automatic ray_beat_type mk_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                           int eta);
      ray_beat_type r;
      r.dx = 16'(dx); r.dy = 16'(dy); r.dz = 16'(dz);
      r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
      r.eta = 16'(eta);
      return r;
   endfunction

   // random ray: unit-ish normal in Q2.14 along a random axis mix, or full-range noise
   function automatic ray_beat_type rand_ray();
      ray_beat_type r;
      int           mode;
      mode = $urandom_range(0, 9);
      r.dx = 16'($urandom); r.dy = 16'($urandom); r.dz = 16'($urandom);
      if (mode < 6) begin
         // unit normal on an axis or diagonal, eta near physical values
         case ($urandom_range(0, 3))
            0: begin r.nx = 16'sd0; r.ny = 16'sd16384; r.nz = 16'sd0; end
            1: begin r.nx = 16'sd0; r.ny = 16'sd0; r.nz = -16'sd16384; end
            2: begin r.nx = 16'sd11585; r.ny = -16'sd11585; r.nz = 16'sd0; end
            default: begin r.nx = 16'sd9459; r.ny = 16'sd9459; r.nz = -16'sd9459; end
         endcase
         r.eta = 16'($urandom_range(8192, 26000));
         if ($urandom_range(0, 3) == 0) begin
            r.dx = 16'(int'($urandom_range(0, 255)) - 128);
            r.dy = 16'(int'($urandom_range(0, 255)) - 128);
         end
      end else begin
         // full-range noise on every field
         r.nx  = 16'($urandom); r.ny = 16'($urandom); r.nz = 16'($urandom);
         r.eta = 16'($urandom);
      end
      return r;
   endfunction

   dir_row_type   dir_rows[$];
   refr_beat_type zero_res;

   initial begin
      zero_res = '{ox: '0, oy: '0, oz: '0, ok: 1'b0};
      // zero direction, with extreme normal and eta
      dir_rows.push_back('{mk_ray(0, 0, 0, 16384, 0, 0, 16384), 1, zero_res});
      dir_rows.push_back('{mk_ray(0, 0, 0, -32768, 32767, -32768, 65535), 1, zero_res});
      // head-on ray through matched media: straight through
      dir_rows.push_back('{mk_ray(0, 0, -4096, 0, 0, 16384, 16384), 1,
                           '{ox: 0, oy: 0, oz: -16384, ok: 1'b1}});
      // total internal reflection: grazing ray with large eta
      dir_rows.push_back('{mk_ray(4096, 0, -1, 0, 0, 16384, 32768), 1, zero_res});
      dir_rows.push_back('{mk_ray(32767, 32767, 32767, 0, 16384, 0, 65535), 1, zero_res});
      // negative discriminant: eta 2, ray at 60 degrees to the normal
      dir_rows.push_back('{mk_ray(3547, -2048, 0, 0, 16384, 0, 32768), 0, zero_res});
      // field extremes, predicted
      dir_rows.push_back('{mk_ray(-32768, -32768, -32768, 16384, 0, 0, 0), 0, zero_res});
      dir_rows.push_back('{mk_ray(32767, -32768, 1, -32768, -32768, -32768, 16384), 0,
                           zero_res});
      dir_rows.push_back('{mk_ray(1, 0, 0, 32767, 32767, 32767, 65535), 0, zero_res});
      dir_rows.push_back('{mk_ray(-1, -1, -1, -16384, 0, 0, 1), 0, zero_res});
      dir_rows.push_back('{mk_ray(0, -32768, 0, 0, 16384, 0, 12288), 0, zero_res});
      dir_rows.push_back('{mk_ray(0, 0, 32767, 0, 0, -32768, 24576), 0, zero_res});
      dir_rows.push_back('{mk_ray(-21845, 10922, 5461, 9459, 9459, 9459, 21845), 0, zero_res});
      // output saturation: oversized normal
      dir_rows.push_back('{mk_ray(4096, 4096, 0, -32768, 32767, 0, 8192), 0, zero_res});
      dir_rows.push_back('{mk_ray(-4096, 0, -4096, 32767, 0, 32767, 4096), 0, zero_res});
   end

   initial begin
      refr_beat_type none;
      none = '{ox: '0, oy: '0, oz: '0, ok: 1'b0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_ray(dir_rows[i].ray, dir_rows[i].has_exp, dir_rows[i].exp_val);

      for (int k = 0; k < N_RANDOM; k++) begin
         // hold off until the pipe drains, then keep the back side flowing
         if (k == N_RANDOM / 2) begin
            req_bus.valid <= 1'b0;
            wait (refr_queue.size() == 0);
            @(posedge clock);
         end
         // stretch with no idling on the response side
         rsp_stall_on <= !(k >= 200 && k < 300);
         if (k >= 200 && k < 300) begin
            send_back_to_back(rand_ray());
         end else begin
            send_ray(rand_ray(), 0, none);
         end
      end
      req_bus.valid <= 1'b0;
      stim_done     <= 1'b1;
   end

   // back-to-back beat: valid stays high for the following beat
   task automatic send_back_to_back(ray_beat_type r);
      req_bus.valid     <= 1'b1;
      req_bus.dir_x     <= r.dx;
      req_bus.dir_y     <= r.dy;
      req_bus.dir_z     <= r.dz;
      req_bus.norm_x    <= r.nx;
      req_bus.norm_y    <= r.ny;
      req_bus.norm_z    <= r.nz;
      req_bus.eta_ratio <= r.eta;
      do @(posedge clock); while (!req_bus.ready);
      refr_queue.push_back(refract(r));
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall, compare each beat against the oldest expectation
   // ------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      refr_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (refr_queue.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected result beat: %0d %0d %0d ok=%0b",
                           rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z,
                           rsp_bus.refracted_ok);
            end else begin
               want = refr_queue.pop_front();
               if (rsp_bus.out_x !== want.ox || rsp_bus.out_y !== want.oy ||
                   rsp_bus.out_z !== want.oz || rsp_bus.refracted_ok !== want.ok) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("mismatch: expected %0d %0d %0d ok=%0b, got %0d %0d %0d ok=%0b",
                              want.ox, want.oy, want.oz, want.ok,
                              rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_z,
                              rsp_bus.refracted_ok);
               end
            end
            stall_left = (rsp_stall_on && $urandom_range(0, 2) != 0) ?
                         $urandom_range(0, MAX_GAP) : 0;
         end
         // advance the stall counter; ready rises when it runs out
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog: cycles in which no beat moves on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      wait (stim_done && refr_queue.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_cnt == 0 && refr_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
